// ===== hdl/bwdt_pkg.sv =====
`default_nettype none

package bwdt_pkg;

	localparam int TABLE_DEPTH   = 8;
	localparam int ALLOWED_SLOTS = 6;

	// Whitelist register file: six address registers, then the count register
	localparam int WL_REGS = 6;
	localparam int ADDR_W  = 48;
	localparam int RSSI_W  = 8;
	localparam int CNT_W   = 4;
	localparam int WLC_W   = 3;
	localparam int CFG_IDX_W = 3;
	localparam int IDX_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	localparam logic [CFG_IDX_W-1:0] REG_ALLOWED_COUNT = CFG_IDX_W'(WL_REGS);
	localparam logic [WLC_W-1:0]     ALLOWED_COUNT_RST = WLC_W'(6);

	typedef enum logic [1:0] {
		MODE_CLEAR = 2'd0,
		MODE_ADV   = 2'd1,
		MODE_DUMP  = 2'd2,
		MODE_NONE  = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_CLEARED = 3'd0,
		ST_ADDED   = 3'd1,
		ST_RAISED  = 3'd2,
		ST_KEPT    = 3'd3,
		ST_DENIED  = 3'd4,
		ST_FULL    = 3'd5,
		ST_ENTRY   = 3'd6,
		ST_EMPTY   = 3'd7
	} status_t;

	typedef struct packed {
		mode_t                     mode;
		logic [ADDR_W-1:0]         beacon_address;
		logic signed [RSSI_W-1:0]  signal_strength;
	} in_item_t;

	typedef struct packed {
		status_t                   status;
		logic [ADDR_W-1:0]         entry_address;
		logic signed [RSSI_W-1:0]  entry_strength;
		logic [CNT_W-1:0]          entry_total;
		logic                      last;
	} out_item_t;

	typedef struct packed {
		logic latch;  // capture the accepted input beat
		logic match;  // register whitelist and table compares
		logic emit;   // perform the action and load one result beat
	} ctl_cmd_t;

	typedef struct packed {
		mode_t mode;
		logic  dump_last;
		logic  out_free;
	} ctl_sts_t;

endpackage

`default_nettype wire

// ===== hdl/beacon_whitelist_dedup_table_top.sv =====
// Flow: an accepted input beat goes through the compare state, then the action
// state, which loads any result beat; an output stall holds that beat there.
// Input stalls until the block is idle again, so one item finishes before the next.
// A dump emits one entry per cycle unless stalled, paced by the single table read port.
// Reset: asynchronous, active low; table emptied, whitelist cleared, count 6.
`default_nettype none

module beacon_whitelist_dedup_table_top (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [bwdt_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [bwdt_pkg::ADDR_W-1:0]    cfg_data,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire bwdt_pkg::in_item_t             in_data,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output bwdt_pkg::out_item_t                 out_data
);
	import bwdt_pkg::*;

	ctl_cmd_t cmd;
	ctl_sts_t sts;

	bwdt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	bwdt_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire

// ===== hdl/bwdt_ctrl.sv =====
`default_nettype none

module bwdt_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire bwdt_pkg::ctl_sts_t sts,
	output bwdt_pkg::ctl_cmd_t     cmd
);
	import bwdt_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_MATCH = 3'b010,
		S_EXEC  = 3'b100
	} state_t;

	state_t state_q, state_d;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_d   = state_q;
		cmd.latch = 1'b0;
		cmd.match = 1'b0;
		cmd.emit  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_d   = S_MATCH;
				end
			end
			S_MATCH: begin
				cmd.match = 1'b1;
				state_d   = S_EXEC;
			end
			S_EXEC: begin
				if (sts.mode == MODE_NONE) begin
					state_d = S_IDLE;
				end else if (sts.out_free) begin
					cmd.emit = 1'b1;
					// dump keeps emitting one entry per beat until the last
					if (sts.mode != MODE_DUMP || sts.dump_last) begin
						state_d = S_IDLE;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/bwdt_dp.sv =====
`default_nettype none

module bwdt_dp (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_we,
	input  wire logic [bwdt_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [bwdt_pkg::ADDR_W-1:0]          cfg_data,
	input  wire bwdt_pkg::in_item_t                   in_data,
	input  wire bwdt_pkg::ctl_cmd_t                   cmd,
	output bwdt_pkg::ctl_sts_t                        sts,
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output bwdt_pkg::out_item_t                       out_data
);
	import bwdt_pkg::*;

	logic [ADDR_W-1:0]        wl_addr_q [WL_REGS];
	logic [WLC_W-1:0]         wl_count_q;

	logic [ADDR_W-1:0]        tbl_addr_q [TABLE_DEPTH];
	logic signed [RSSI_W-1:0] tbl_rssi_q [TABLE_DEPTH];
	logic [CNT_W-1:0]         held_q;

	in_item_t                 item_q;
	logic                     allowed_q;
	logic                     hit_q;
	logic [IDX_W-1:0]         rd_idx_q;

	logic                     out_valid_q;
	out_item_t                out_q;
	out_item_t                out_d;

	logic                     allowed_c;
	logic                     hit_c;
	logic [IDX_W-1:0]         hit_idx_c;
	logic signed [RSSI_W-1:0] rd_rssi;
	logic [ADDR_W-1:0]        rd_addr;
	logic                     stronger;
	logic                     has_room;
	logic                     out_free;
	logic [CNT_W-1:0]         rd_next;

	// Config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WL_REGS; i++) begin
				wl_addr_q[i] <= '0;
			end
			wl_count_q <= ALLOWED_COUNT_RST;
		end else if (cfg_we) begin
			for (int i = 0; i < WL_REGS; i++) begin
				if (cfg_index == CFG_IDX_W'(i)) begin
					wl_addr_q[i] <= cfg_data;
				end
			end
			if (cfg_index == REG_ALLOWED_COUNT) begin
				wl_count_q <= cfg_data[WLC_W-1:0];
			end
		end
	end

	// Parallel compares: whitelist slots and held table entries.
	// Slots past ALLOWED_SLOTS are never looked at, which clamps the count.
	always_comb begin
		allowed_c = 1'b0;
		for (int i = 0; i < ALLOWED_SLOTS; i++) begin
			if (wl_count_q > WLC_W'(i) && wl_addr_q[i] == item_q.beacon_address) begin
				allowed_c = 1'b1;
			end
		end
		hit_c     = 1'b0;
		hit_idx_c = '0;
		for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
			if (held_q > CNT_W'(i) && tbl_addr_q[i] == item_q.beacon_address) begin
				hit_c     = 1'b1;
				hit_idx_c = IDX_W'(i);
			end
		end
	end

	assign rd_rssi  = tbl_rssi_q[rd_idx_q];
	assign rd_addr  = tbl_addr_q[rd_idx_q];
	assign stronger = item_q.signal_strength > rd_rssi;
	assign has_room = held_q < CNT_W'(TABLE_DEPTH);
	assign rd_next  = CNT_W'(rd_idx_q) + CNT_W'(1);
	assign out_free = !out_valid_q || !out_stall;

	assign sts.mode      = item_q.mode;
	assign sts.dump_last = (held_q == '0) || (rd_next == held_q);
	assign sts.out_free  = out_free;

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			item_q <= in_data;
		end
		if (cmd.match) begin
			allowed_q <= allowed_c;
			hit_q     <= hit_c;
			rd_idx_q  <= (item_q.mode == MODE_DUMP) ? '0 : hit_idx_c;
		end else if (cmd.emit && item_q.mode == MODE_DUMP) begin
			rd_idx_q <= rd_next[IDX_W-1:0];
		end
		if (cmd.emit && item_q.mode == MODE_ADV && allowed_q) begin
			if (hit_q) begin
				if (stronger) begin
					tbl_rssi_q[rd_idx_q] <= item_q.signal_strength;
				end
			end else if (has_room) begin
				tbl_addr_q[held_q[IDX_W-1:0]] <= item_q.beacon_address;
				tbl_rssi_q[held_q[IDX_W-1:0]] <= item_q.signal_strength;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
		end else if (cmd.emit) begin
			if (item_q.mode == MODE_CLEAR) begin
				held_q <= '0;
			end else if (item_q.mode == MODE_ADV && allowed_q && !hit_q && has_room) begin
				held_q <= held_q + CNT_W'(1);
			end
		end
	end

	// Result beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		out_d.status         = ST_CLEARED;
		out_d.entry_address  = item_q.beacon_address;
		out_d.entry_strength = item_q.signal_strength;
		out_d.entry_total    = held_q;
		out_d.last           = 1'b1;
		case (item_q.mode)
			MODE_CLEAR: begin
				out_d.status         = ST_CLEARED;
				out_d.entry_strength = '0;
				out_d.entry_total    = '0;
			end
			MODE_ADV: begin
				if (!allowed_q) begin
					out_d.status = ST_DENIED;
				end else if (hit_q) begin
					if (stronger) begin
						out_d.status = ST_RAISED;
					end else begin
						out_d.status         = ST_KEPT;
						out_d.entry_strength = rd_rssi;
					end
				end else if (has_room) begin
					out_d.status      = ST_ADDED;
					out_d.entry_total = held_q + CNT_W'(1);
				end else begin
					out_d.status = ST_FULL;
				end
			end
			default: begin
				if (held_q == '0) begin
					out_d.status         = ST_EMPTY;
					out_d.entry_strength = '0;
				end else begin
					out_d.status         = ST_ENTRY;
					out_d.entry_address  = rd_addr;
					out_d.entry_strength = rd_rssi;
					out_d.last           = (rd_next == held_q);
				end
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q <= out_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef SYNTHESIS
	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= CNT_W'(TABLE_DEPTH))
		else $error("table count past depth");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid_q || !out_stall))
		else $error("result beat overwritten while stalled");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && item_q.mode == MODE_CLEAR) |=> (held_q == '0))
		else $error("clear left entries");

	a_entry_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.status == ST_ENTRY) |-> (out_q.entry_total != '0))
		else $error("dump entry from empty table");
`endif

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import bwdt_pkg::*;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int SETTLE_CYCLES = 12;   // covers the match and exec states plus margin
	localparam int LONG_HOLD     = 400;
	localparam int PHASE_ITEMS   = 26;

	localparam logic [CFG_IDX_W-1:0] REG_ALLOWED_ADDR0 = '0;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED        = '1;
	localparam logic [ADDR_W-1:0]    ADDR_ONES         = '1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [ADDR_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_item_t out_data;

	beacon_whitelist_dedup_table_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// scoreboard copy of the whitelist and the batch table
	logic [ADDR_W-1:0] wl_addr [ALLOWED_SLOTS];
	logic [WLC_W-1:0] wl_count;
	logic [ADDR_W-1:0] tbl_addr [TABLE_DEPTH];
	logic signed [RSSI_W-1:0] tbl_rssi [TABLE_DEPTH];
	int tbl_held;

	in_item_t pending_items [$];
	out_item_t expected_beats [$];

	int error_count = 0;
	int cycle_count = 0;
	bit in_taken = 1'b0;
	bit out_taken = 1'b0;
	int tx_wait = 0;
	int rx_wait = 0;
	int tx_gap_max = 13;
	int rx_gap_max = 13;
	bit hold_req = 1'b0;
	bit hold_seen = 1'b0;
	int hold_left = 0;

	function automatic out_item_t mk_beat(status_t st, logic [ADDR_W-1:0] a,
			logic signed [RSSI_W-1:0] s, logic lst);
		out_item_t b;
		b.status = st;
		b.entry_address = a;
		b.entry_strength = s;
		b.entry_total = CNT_W'(tbl_held);
		b.last = lst;
		return b;
	endfunction

	function automatic void predict_table(in_item_t it);
		int lim;
		int slot;
		bit hit;
		status_t st;
		lim = (wl_count > ALLOWED_SLOTS) ? ALLOWED_SLOTS : int'(wl_count);
		hit = 1'b0;
		slot = -1;
		case (it.mode)
			MODE_CLEAR: begin
				tbl_held = 0;
				expected_beats.push_back(mk_beat(ST_CLEARED, it.beacon_address, '0, 1'b1));
			end
			MODE_ADV: begin
				for (int i = 0; i < lim; i++)
					if (wl_addr[i] == it.beacon_address)
						hit = 1'b1;
				if (!hit) begin
					expected_beats.push_back(mk_beat(ST_DENIED, it.beacon_address,
						it.signal_strength, 1'b1));
				end else begin
					for (int i = 0; i < tbl_held; i++)
						if (slot < 0 && tbl_addr[i] == it.beacon_address)
							slot = i;
					if (slot >= 0) begin
						st = ST_KEPT;
						if (it.signal_strength > tbl_rssi[slot]) begin
							tbl_rssi[slot] = it.signal_strength;
							st = ST_RAISED;
						end
						expected_beats.push_back(mk_beat(st, it.beacon_address,
							tbl_rssi[slot], 1'b1));
					end else if (tbl_held < TABLE_DEPTH) begin
						tbl_addr[tbl_held] = it.beacon_address;
						tbl_rssi[tbl_held] = it.signal_strength;
						tbl_held++;
						expected_beats.push_back(mk_beat(ST_ADDED, it.beacon_address,
							it.signal_strength, 1'b1));
					end else begin
						expected_beats.push_back(mk_beat(ST_FULL, it.beacon_address,
							it.signal_strength, 1'b1));
					end
				end
			end
			MODE_DUMP: begin
				if (tbl_held == 0)
					expected_beats.push_back(mk_beat(ST_EMPTY, it.beacon_address, '0, 1'b1));
				for (int i = 0; i < tbl_held; i++)
					expected_beats.push_back(mk_beat(ST_ENTRY, tbl_addr[i], tbl_rssi[i],
						i == tbl_held - 1));
			end
			default: ;  // unused mode: no result, no change
		endcase
	endfunction

	task automatic report(string what, logic [ADDR_W-1:0] got, logic [ADDR_W-1:0] want);
		error_count++;
		$display("mismatch at cycle %0d: %s got 0x%0h want 0x%0h", cycle_count, what, got,
			want);
	endtask

	task automatic check_beat(out_item_t got);
		out_item_t want;
		if (expected_beats.size() == 0) begin
			report("unexpected beat, status", ADDR_W'(got.status), '0);
		end else begin
			want = expected_beats.pop_front();
			if (got.status !== want.status)
				report("status", ADDR_W'(got.status), ADDR_W'(want.status));
			if (got.entry_address !== want.entry_address)
				report("entry_address", got.entry_address, want.entry_address);
			if (got.entry_strength !== want.entry_strength)
				report("entry_strength", ADDR_W'(got.entry_strength),
					ADDR_W'(want.entry_strength));
			if (got.entry_total !== want.entry_total)
				report("entry_total", ADDR_W'(got.entry_total), ADDR_W'(want.entry_total));
			if (got.last !== want.last)
				report("last", ADDR_W'(got.last), ADDR_W'(want.last));
		end
	endtask

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("FAILURE");
			$finish;
		end else begin
			in_taken = arst_n && in_valid && !in_stall;
			out_taken = arst_n && out_valid && !out_stall;
			if (out_taken)
				check_beat(out_data);
			if (in_taken)
				predict_table(in_data);
		end
	end

	// sender: one beat at a time, random gap after each accepted beat
	always @(negedge clk) begin : sender
		logic nxt_valid;
		in_item_t nxt_data;
		nxt_valid = in_valid;
		nxt_data = in_data;
		if (in_valid && in_taken) begin
			nxt_valid = 1'b0;
			tx_wait = $urandom_range(0, tx_gap_max);
		end
		if (!nxt_valid) begin
			if (tx_wait > 0) begin
				tx_wait--;
			end else if (pending_items.size() != 0) begin
				nxt_data = pending_items.pop_front();
				nxt_valid = 1'b1;
			end
		end
		in_valid <= nxt_valid;
		in_data <= nxt_data;
	end

	// receiver: random stall after each beat, plus a long hold on request
	always @(negedge clk) begin : receiver
		if (hold_req != hold_seen) begin
			hold_seen = hold_req;
			hold_left = LONG_HOLD;
		end
		if (out_taken)
			rx_wait = $urandom_range(0, rx_gap_max);
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (rx_wait > 0) begin
			rx_wait--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	function automatic in_item_t mk_item(mode_t m, logic [ADDR_W-1:0] a,
			logic signed [RSSI_W-1:0] s);
		in_item_t it;
		it.mode = m;
		it.beacon_address = a;
		it.signal_strength = s;
		return it;
	endfunction

	function automatic logic [ADDR_W-1:0] rand_addr();
		return {16'($urandom), 32'($urandom)};
	endfunction

	function automatic in_item_t rand_item();
		int r;
		int pick;
		logic [ADDR_W-1:0] a;
		r = $urandom_range(0, 99);
		pick = $urandom_range(0, 99);
		// most advertisements hit a whitelist slot, some a near miss or noise
		if (pick < 70)
			a = wl_addr[$urandom_range(0, ALLOWED_SLOTS - 1)];
		else if (pick < 85)
			a = wl_addr[$urandom_range(0, ALLOWED_SLOTS - 1)] ^
				(ADDR_W'(1) << $urandom_range(0, ADDR_W - 1));
		else
			a = rand_addr();
		if (r < 8)
			return mk_item(MODE_DUMP, rand_addr(), RSSI_W'($urandom));
		if (r < 12)
			return mk_item(MODE_CLEAR, rand_addr(), RSSI_W'($urandom));
		if (r < 14)
			return mk_item(MODE_NONE, rand_addr(), RSSI_W'($urandom));
		return mk_item(MODE_ADV, a, RSSI_W'($urandom));
	endfunction

	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		if (idx < REG_ALLOWED_COUNT)
			wl_addr[idx] = val;
		else if (idx == REG_ALLOWED_COUNT)
			wl_count = val[WLC_W-1:0];
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// wait until the block is idle; the extra cycles cover items with no result
	task automatic drain();
		while (pending_items.size() != 0 || in_valid || expected_beats.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin : stimulus
		logic [ADDR_W-1:0] a;
		int pick;
		logic [WLC_W-1:0] phase_count [6];
		phase_count = '{3'd7, 3'd6, 3'd3, 3'd1, 3'd6, 3'd5};

		for (int i = 0; i < ALLOWED_SLOTS; i++)
			wl_addr[i] = '0;
		wl_count = ALLOWED_COUNT_RST;
		tbl_held = 0;

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset whitelist: every slot holds address zero
		pending_items.push_back(mk_item(MODE_DUMP, ADDR_ONES, 8'sd0));
		pending_items.push_back(mk_item(MODE_ADV, '0, -8'sd128));
		pending_items.push_back(mk_item(MODE_ADV, '0, -8'sd128));
		pending_items.push_back(mk_item(MODE_ADV, '0, 8'sd127));
		pending_items.push_back(mk_item(MODE_ADV, '0, 8'sd5));
		pending_items.push_back(mk_item(MODE_ADV, ADDR_ONES, -8'sd1));
		pending_items.push_back(mk_item(MODE_NONE, ADDR_ONES, 8'sd127));
		pending_items.push_back(mk_item(MODE_DUMP, '0, 8'sd0));
		pending_items.push_back(mk_item(MODE_CLEAR, ADDR_ONES, -8'sd128));
		pending_items.push_back(mk_item(MODE_DUMP, '0, 8'sd0));
		drain();

		// extremes in the whitelist, plus a write to the unused index
		cfg_write(REG_ALLOWED_ADDR0, '0);
		cfg_write(REG_ALLOWED_ADDR0 + CFG_IDX_W'(1), ADDR_ONES);
		for (int i = 2; i < ALLOWED_SLOTS; i++)
			cfg_write(REG_ALLOWED_ADDR0 + CFG_IDX_W'(i), rand_addr());
		cfg_write(REG_ALLOWED_COUNT, ADDR_W'(ALLOWED_SLOTS));
		cfg_write(REG_UNUSED, ADDR_ONES);
		for (int i = 0; i < ALLOWED_SLOTS; i++)
			pending_items.push_back(mk_item(MODE_ADV, wl_addr[i], RSSI_W'($urandom)));
		pending_items.push_back(mk_item(MODE_ADV, ADDR_ONES, -8'sd128));
		pending_items.push_back(mk_item(MODE_ADV, rand_addr(), 8'sd127));
		pending_items.push_back(mk_item(MODE_DUMP, rand_addr(), 8'sd0));
		pending_items.push_back(mk_item(MODE_CLEAR, '0, 8'sd0));
		drain();

		// zero whitelist count: nothing is allowed
		cfg_write(REG_ALLOWED_COUNT, '0);
		pending_items.push_back(mk_item(MODE_ADV, '0, 8'sd1));
		pending_items.push_back(mk_item(MODE_ADV, ADDR_ONES, -8'sd2));
		pending_items.push_back(mk_item(MODE_DUMP, '0, 8'sd0));
		drain();

		for (int p = 0; p < 6; p++) begin
			for (int i = 0; i < ALLOWED_SLOTS; i++) begin
				pick = $urandom_range(0, 99);
				if (pick < 10)
					a = '0;
				else if (pick < 20)
					a = ADDR_ONES;
				else if (pick < 35 && i > 0)
					a = wl_addr[0];
				else
					a = rand_addr();
				cfg_write(REG_ALLOWED_ADDR0 + CFG_IDX_W'(i), a);
			end
			cfg_write(REG_ALLOWED_COUNT, ADDR_W'(phase_count[p]));
			if (p == 2)
				cfg_write(REG_UNUSED, rand_addr());
			tx_gap_max = (p % 3 == 1) ? 0 : 13;
			rx_gap_max = (p % 2 == 1) ? 0 : 13;
			if (p == 4) begin
				// receiver holds off while the sender keeps pushing back to back
				tx_gap_max = 0;
				hold_req = !hold_req;
			end
			for (int k = 0; k < PHASE_ITEMS; k++)
				pending_items.push_back(rand_item());
			drain();
		end

		if (error_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
